// ===== hw/rtl/relative_path_safety_checker_core_macros.svh =====
// Assertion helpers used by the checker core RTL.
`ifndef RELATIVE_PATH_SAFETY_CHECKER_CORE_MACROS_SVH
`define RELATIVE_PATH_SAFETY_CHECKER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPSC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("rpsc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define RPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("rpsc: next-cycle check failed");

`endif

// ===== hw/rtl/rpsc_pkg.sv =====
package rpsc_pkg;

    localparam int PATH_LEN_W = 13;
    localparam int COMP_LEN_W = 9;
    localparam int SEG_CNT_W  = 10;
    localparam int CFG_IDX_W  = 1;

    localparam logic [PATH_LEN_W-1:0] MAX_PATH_LEN_RST = 13'd4096;
    localparam logic [COMP_LEN_W-1:0] MAX_COMP_LEN_RST = 9'd255;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PATH_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_COMP_LEN = 1'b1;

    localparam logic [7:0] CH_SLASH  = 8'h2f;
    localparam logic [7:0] CH_DOT    = 8'h2e;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DEL    = 8'h7f;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_COLON  = 8'h3a;
    localparam logic [7:0] CH_LT     = 8'h3c;
    localparam logic [7:0] CH_GT     = 8'h3e;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_PIPE   = 8'h7c;
    localparam logic [7:0] CH_QMARK  = 8'h3f;
    localparam logic [7:0] CH_STAR   = 8'h2a;
    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7a;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_DIFF = 8'h20;

    // Stem length code: 5 means the stem is longer than four bytes.
    localparam logic [2:0] STEM_FULL = 3'd4;
    localparam logic [2:0] STEM_OVER = 3'd5;
    localparam logic [2:0] STEM_THREE = 3'd3;

    localparam logic [23:0] DEV_CON = 24'h434f4e;
    localparam logic [23:0] DEV_PRN = 24'h50524e;
    localparam logic [23:0] DEV_AUX = 24'h415558;
    localparam logic [23:0] DEV_NUL = 24'h4e554c;
    localparam logic [23:0] DEV_COM = 24'h434f4d;
    localparam logic [23:0] DEV_LPT = 24'h4c5054;

    typedef struct packed {
        logic       is_slash;
        logic       is_dot;
        logic       bad_end;    // '.' or space, not allowed to end a component
        logic       forbidden;
        logic [7:0] upper;
    } t_byte_class;

    function automatic logic stem_is_device(input logic [31:0] chars, input logic [2:0] count);
        logic [23:0] s3;
        logic [7:0]  d;
        logic        hit;
        s3  = '0;
        d   = chars[7:0];
        hit = 1'b0;
        if (count == STEM_THREE) begin
            s3  = chars[23:0];
            hit = (s3 == DEV_CON) || (s3 == DEV_PRN) || (s3 == DEV_AUX) || (s3 == DEV_NUL);
        end else if (count == STEM_FULL) begin
            s3  = chars[31:8];
            hit = ((s3 == DEV_COM) || (s3 == DEV_LPT)) && (d >= CH_ONE) && (d <= CH_NINE);
        end
        return hit;
    endfunction

endpackage

// ===== hw/rtl/rpsc_byte_class.sv =====
module rpsc_byte_class (
    input  logic [7:0]                i_byte,
    output rpsc_pkg::t_byte_class     o_class
);
    import rpsc_pkg::*;

    always_comb begin
        o_class.is_slash  = (i_byte == CH_SLASH);
        o_class.is_dot    = (i_byte == CH_DOT);
        o_class.bad_end   = (i_byte == CH_DOT) || (i_byte == CH_SPACE);
        o_class.forbidden = (i_byte < CH_SPACE) || (i_byte == CH_DEL) ||
                            (i_byte == CH_BSLASH) || (i_byte == CH_COLON) ||
                            (i_byte == CH_LT) || (i_byte == CH_GT) ||
                            (i_byte == CH_QUOTE) || (i_byte == CH_PIPE) ||
                            (i_byte == CH_QMARK) || (i_byte == CH_STAR);
        if ((i_byte >= CH_LOW_A) && (i_byte <= CH_LOW_Z)) begin
            o_class.upper = i_byte - CASE_DIFF;
        end else begin
            o_class.upper = i_byte;
        end
    end

endmodule

// ===== hw/rtl/relative_path_safety_checker_core.sv =====
// A byte accepted into the input register is evaluated there and, if it is the last byte, its verdict is
// captured in the result register, from which it is offered on the verdict stream.
// Throughput: one byte per cycle; a last byte waits only while the previous verdict is not taken.
// The running flags and counters are updated once per byte, between the input
// register and the result register.
// Reset (synchronous, active low) restores the limits to 4096 and 255 and clears the path state.
`include "relative_path_safety_checker_core_macros.svh"

module relative_path_safety_checker_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Configuration write port.
    input  logic                           i_cfg_we,
    input  logic [rpsc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [12:0]                    i_cfg_wdata,
    // Input stream.
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [7:0]                     i_s_tdata,   // [7:0] path_byte
    input  logic                           i_s_tlast,   // last_byte
    // Verdict stream.
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [7:0]                     o_m_tdata    // [0] path_is_safe, [7:1] zero
);
    import rpsc_pkg::*;

    logic [PATH_LEN_W-1:0] r_max_path;
    logic [COMP_LEN_W-1:0] r_max_comp;

    logic                  r_in_valid;
    logic [7:0]            r_in_byte;
    logic                  r_in_last;

    logic [PATH_LEN_W-1:0] r_total,      n_total;
    logic [SEG_CNT_W-1:0]  r_seg,        n_seg;
    logic                  r_prev_bad,   n_prev_bad;
    logic [31:0]           r_stem_chars, n_stem_chars;
    logic [2:0]            r_stem_count, n_stem_count;
    logic                  r_dot,        n_dot;
    logic                  r_fault,      n_fault;
    logic                  n_verdict_fault;

    logic                  r_out_valid;
    logic                  r_out_safe;

    logic                  out_free;
    logic                  proc;
    t_byte_class           cls;

    logic [PATH_LEN_W:0]   total_inc;
    logic [SEG_CNT_W:0]    seg_inc;

    rpsc_byte_class u_byte_class (
        .i_byte  (r_in_byte),
        .o_class (cls)
    );

    assign out_free   = !r_out_valid || i_m_tready;
    assign proc       = r_in_valid && (!r_in_last || out_free);
    assign o_s_tready = !r_in_valid || proc;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {7'd0, r_out_safe};

    assign total_inc = {1'b0, r_total} + {{PATH_LEN_W{1'b0}}, 1'b1};
    assign seg_inc   = {1'b0, r_seg} + {{SEG_CNT_W{1'b0}}, 1'b1};

    always_comb begin
        n_fault      = r_fault;
        n_total      = r_total;
        n_seg        = r_seg;
        n_stem_chars = r_stem_chars;
        n_stem_count = r_stem_count;
        n_dot        = r_dot;
        n_prev_bad   = cls.bad_end;

        // The fault test uses the full sum so that a saturated count still fails.
        if (total_inc > {1'b0, r_max_path}) begin
            n_fault = 1'b1;
        end
        if (!(&r_total)) begin
            n_total = total_inc[PATH_LEN_W-1:0];
        end

        if (!cls.is_slash) begin
            if (cls.forbidden) begin
                n_fault = 1'b1;
            end
            if (seg_inc > {2'b00, r_max_comp}) begin
                n_fault = 1'b1;
            end
            if (!(&r_seg)) begin
                n_seg = seg_inc[SEG_CNT_W-1:0];
            end
            if (!r_dot) begin
                if (cls.is_dot) begin
                    n_dot = 1'b1;
                end else if (r_stem_count < STEM_FULL) begin
                    n_stem_chars = {r_stem_chars[23:0], cls.upper};
                    n_stem_count = r_stem_count + 3'd1;
                end else begin
                    n_stem_count = STEM_OVER;
                end
            end
        end

        // Component end: a slash closes the previous component, the last byte closes its own.
        if (cls.is_slash || r_in_last) begin
            if (n_seg == '0) begin
                n_fault = 1'b1;
            end
            if (cls.is_slash ? r_prev_bad : cls.bad_end) begin
                n_fault = 1'b1;
            end
            if (stem_is_device(n_stem_chars, n_stem_count)) begin
                n_fault = 1'b1;
            end
            if (cls.is_slash && r_in_last) begin
                n_fault = 1'b1;
            end
            if (cls.is_slash) begin
                n_seg        = '0;
                n_stem_chars = '0;
                n_stem_count = '0;
                n_dot        = 1'b0;
            end
        end

        n_verdict_fault = n_fault;

        if (r_in_last) begin
            n_fault      = 1'b0;
            n_total      = '0;
            n_seg        = '0;
            n_stem_chars = '0;
            n_stem_count = '0;
            n_dot        = 1'b0;
            n_prev_bad   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_path <= MAX_PATH_LEN_RST;
            r_max_comp <= MAX_COMP_LEN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_MAX_PATH_LEN: r_max_path <= i_cfg_wdata;
                REG_MAX_COMP_LEN: r_max_comp <= i_cfg_wdata[COMP_LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_byte <= i_s_tdata;
            r_in_last <= i_s_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total      <= '0;
            r_seg        <= '0;
            r_prev_bad   <= 1'b0;
            r_stem_chars <= '0;
            r_stem_count <= '0;
            r_dot        <= 1'b0;
            r_fault      <= 1'b0;
        end else if (proc) begin
            r_total      <= n_total;
            r_seg        <= n_seg;
            r_prev_bad   <= n_prev_bad;
            r_stem_chars <= n_stem_chars;
            r_stem_count <= n_stem_count;
            r_dot        <= n_dot;
            r_fault      <= n_fault;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc && r_in_last) begin
            r_out_safe <= !n_verdict_fault;
        end
    end

    `RPSC_ASSERT_NEXT(a_last_clears_state, i_clk, i_rst_n, proc && r_in_last, (r_total == '0) && !r_fault && (r_seg == '0))
    `RPSC_ASSERT_NEXT(a_last_gives_word, i_clk, i_rst_n, proc && r_in_last, r_out_valid)
    `RPSC_ASSERT_NOW(a_seg_within_total, i_clk, i_rst_n, 1'b1, {3'b000, r_seg} <= r_total)
    `RPSC_ASSERT_NEXT(a_fault_sticks, i_clk, i_rst_n, r_fault && !(proc && r_in_last), r_fault)

endmodule
